/* src/sorted_table_floor_search_unit_macros.svh */
// Assertion macros shared by the checker of the floor search unit.
// Depends on nothing; the using scope supplies clk and rst.
`ifndef SORTED_TABLE_FLOOR_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_FLOOR_SEARCH_UNIT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define STFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define STFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/stfs_pkg.sv */
// Shared constants, codes and control types of the floor search unit.
// No dependencies.
package stfs_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W        = 64;
  localparam int ENTRY_INDEX_W = 10;
  localparam int ENTRY_COUNT_W = 11;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SEARCH,
    ST_DONE
  } stfs_state_t;

  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_MID_INIT,
    ADDR_MID_STEP
  } stfs_addr_sel_t;

  typedef struct packed {
    logic           capture_query;
    logic           write_entry;
    logic           clear_result;
    logic           take_first;
    logic           take_last;
    logic           start_search;
    logic           step;
    logic           load_out;
    stfs_addr_sel_t addr_sel;
  } stfs_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic query_below;
    logic last_gt1;
    logic span_gt1;
  } stfs_status_t;

endpackage

/* src/sorted_table_floor_search_unit.sv */
// Floor lookup in a sorted table of (start address, record offset) pairs.
// Writes: one request a cycle while idle, no result. Lookups end on an empty table,
// after the first probe (query below the first entry), after the last-entry probe (no
// bisection needed), else after bisection, one probe a cycle on the single read port.
// The next request enters once the result is loaded and the sequencer is idle again.
// Reset (rst, synchronous) clears entry_count and the sequencer, not the table.
module sorted_table_floor_search_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [stfs_pkg::ENTRY_COUNT_W-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [stfs_pkg::ENTRY_INDEX_W-1:0] entry_index,
  input  logic [stfs_pkg::DATA_W-1:0]        entry_start,
  input  logic [stfs_pkg::DATA_W-1:0]        entry_record,
  input  logic [stfs_pkg::DATA_W-1:0]        query_address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [stfs_pkg::DATA_W-1:0]        record_offset
);

  // Commands from the sequencer and status back from the datapath.
  stfs_pkg::stfs_cmd_t    cmd;
  stfs_pkg::stfs_status_t status;

  // The sequencer accepts a request only when idle; a finished result sits
  // in the output register, so the next request may enter while it waits.
  stfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds both table memories, the bisection bounds and the
  // registered result; every memory read is registered, so each probe's
  // start address is compared in the cycle after its address is issued.
  stfs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .entry_index   (entry_index),
    .entry_start   (entry_start),
    .entry_record  (entry_record),
    .query_address (query_address),
    .cmd           (cmd),
    .status        (status),
    .found         (found),
    .record_offset (record_offset)
  );

endmodule

/* src/stfs_ctrl.sv */
// Sequencer of the floor search unit: handshakes and search steps.
// Depends on stfs_pkg.
module stfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  output logic               out_valid,
  input  logic               out_ready,
  input  stfs_pkg::stfs_status_t status,
  output stfs_pkg::stfs_cmd_t    cmd
);

  stfs_pkg::stfs_state_t state, state_next;
  logic                  out_valid_next;
  logic                  in_fire;
  logic                  out_free;

  assign in_fire  = in_valid && (state == stfs_pkg::ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stfs_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      stfs_pkg::ST_IDLE: begin
        if (in_fire && (command == stfs_pkg::CMD_LOOKUP)) begin
          state_next = status.count_zero ? stfs_pkg::ST_DONE : stfs_pkg::ST_CHK_FIRST;
        end
      end
      stfs_pkg::ST_CHK_FIRST: begin
        state_next = status.query_below ? stfs_pkg::ST_DONE : stfs_pkg::ST_CHK_LAST;
      end
      stfs_pkg::ST_CHK_LAST: begin
        if (!status.query_below || !status.last_gt1) begin
          state_next = stfs_pkg::ST_DONE;
        end else begin
          state_next = stfs_pkg::ST_SEARCH;
        end
      end
      stfs_pkg::ST_SEARCH: begin
        if (!status.span_gt1) begin
          state_next = stfs_pkg::ST_DONE;
        end
      end
      stfs_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = stfs_pkg::ST_IDLE;
        end
      end
      default: state_next = stfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.addr_sel   = stfs_pkg::ADDR_HOLD;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      stfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (command == stfs_pkg::CMD_LOOKUP) begin
            cmd.capture_query = 1'b1;
            cmd.clear_result  = status.count_zero;
            cmd.addr_sel      = stfs_pkg::ADDR_ZERO;
          end else begin
            cmd.write_entry = 1'b1;
          end
        end
      end
      stfs_pkg::ST_CHK_FIRST: begin
        cmd.take_first = 1'b1;
        cmd.addr_sel   = stfs_pkg::ADDR_LAST;
      end
      stfs_pkg::ST_CHK_LAST: begin
        cmd.take_last = 1'b1;
        if (status.query_below && status.last_gt1) begin
          cmd.start_search = 1'b1;
          cmd.addr_sel     = stfs_pkg::ADDR_MID_INIT;
        end
      end
      stfs_pkg::ST_SEARCH: begin
        cmd.step     = 1'b1;
        cmd.addr_sel = stfs_pkg::ADDR_MID_STEP;
      end
      stfs_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        cmd.addr_sel = stfs_pkg::ADDR_HOLD;
      end
    endcase
  end

endmodule

/* src/stfs_datapath.sv */
// Datapath of the floor search unit: table memories, bounds, compare
// and result registers. Depends on stfs_pkg.
module stfs_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [stfs_pkg::ENTRY_COUNT_W-1:0]      cfg_data,
  input  logic [stfs_pkg::ENTRY_INDEX_W-1:0]      entry_index,
  input  logic [stfs_pkg::DATA_W-1:0]             entry_start,
  input  logic [stfs_pkg::DATA_W-1:0]             entry_record,
  input  logic [stfs_pkg::DATA_W-1:0]             query_address,
  input  stfs_pkg::stfs_cmd_t                     cmd,
  output stfs_pkg::stfs_status_t                  status,
  output logic                                    found,
  output logic [stfs_pkg::DATA_W-1:0]             record_offset
);

  logic [stfs_pkg::DATA_W-1:0] start_store  [stfs_pkg::TABLE_DEPTH];
  logic [stfs_pkg::DATA_W-1:0] record_store [stfs_pkg::TABLE_DEPTH];

  logic [stfs_pkg::ENTRY_COUNT_W-1:0] entry_count;
  logic [stfs_pkg::CNT_W-1:0]         count_sat;
  logic [stfs_pkg::CNT_W-1:0]         count_less1;
  logic [stfs_pkg::IDX_W-1:0]         last;
  logic [stfs_pkg::DATA_W-1:0]        query;
  logic [stfs_pkg::DATA_W-1:0]        rd_start;
  logic [stfs_pkg::DATA_W-1:0]        rd_record;
  logic [stfs_pkg::IDX_W-1:0]         rd_addr, rd_addr_next;
  logic [stfs_pkg::IDX_W-1:0]         lo, lo_next;
  logic [stfs_pkg::IDX_W-1:0]         hi, hi_next;
  logic [stfs_pkg::IDX_W-1:0]         span_next;
  logic [stfs_pkg::IDX_W-1:0]         wr_addr;
  logic                               wr_en;
  logic                               query_below;
  logic                               res_found;
  logic [stfs_pkg::DATA_W-1:0]        res_record;

  // Saturate the entry count at the table depth.
  always_comb begin
    if (32'(entry_count) > stfs_pkg::TABLE_DEPTH) begin
      count_sat = stfs_pkg::CNT_W'(stfs_pkg::TABLE_DEPTH);
    end else begin
      count_sat = stfs_pkg::CNT_W'(entry_count);
    end
  end

  assign count_less1 = count_sat - stfs_pkg::CNT_W'(1);
  assign last        = count_less1[stfs_pkg::IDX_W-1:0];
  assign query_below = query < rd_start;

  // Next bounds of one bisection step: keep the probe as low when not above.
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (!query_below) begin
      lo_next = rd_addr;
    end else begin
      hi_next = rd_addr;
    end
  end

  assign span_next = hi_next - lo_next;

  always_comb begin
    case (cmd.addr_sel)
      stfs_pkg::ADDR_HOLD:     rd_addr_next = rd_addr;
      stfs_pkg::ADDR_ZERO:     rd_addr_next = '0;
      stfs_pkg::ADDR_LAST:     rd_addr_next = last;
      stfs_pkg::ADDR_MID_INIT: rd_addr_next = last >> 1;
      stfs_pkg::ADDR_MID_STEP: rd_addr_next = lo_next + (span_next >> 1);
      default:                 rd_addr_next = rd_addr;
    endcase
  end

  assign status.count_zero  = (count_sat == '0);
  assign status.query_below = query_below;
  assign status.last_gt1    = (last > stfs_pkg::IDX_W'(1));
  assign status.span_gt1    = (span_next > stfs_pkg::IDX_W'(1));

  assign wr_addr = stfs_pkg::IDX_W'(entry_index);
  assign wr_en   = cmd.write_entry && (32'(entry_index) < stfs_pkg::TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_store[wr_addr] <= entry_start;
    end
    rd_start <= start_store[rd_addr_next];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      record_store[wr_addr] <= entry_record;
    end
    rd_record <= record_store[rd_addr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write) begin
      entry_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= rd_addr_next;
    if (cmd.capture_query) begin
      query <= query_address;
    end
    if (cmd.start_search) begin
      lo <= '0;
      hi <= last;
    end else if (cmd.step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (cmd.clear_result) begin
      res_found  <= 1'b0;
      res_record <= '0;
    end else if (cmd.take_first) begin
      res_found  <= !query_below;
      res_record <= query_below ? '0 : rd_record;
    end else if ((cmd.take_last || cmd.step) && !query_below) begin
      res_record <= rd_record;
    end
    if (cmd.load_out) begin
      found         <= res_found;
      record_offset <= res_record;
    end
  end

endmodule

/* src/stfs_checker.sv */
// Port-level checker of the floor search unit, bound to the top level.
// Depends on stfs_pkg and sorted_table_floor_search_unit_macros.svh.
`include "sorted_table_floor_search_unit_macros.svh"

module stfs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        command,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        found,
  input logic [stfs_pkg::DATA_W-1:0] record_offset
);

  `STFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
    "result dropped before it was taken")

  `STFS_ASSERT_SAME(a_miss_zero, out_valid && !found, record_offset == '0,
    "miss result carries a non-zero offset")

  `STFS_ASSERT_NEXT(a_write_silent,
    in_valid && in_ready && (command == stfs_pkg::CMD_WRITE) && !out_valid,
    !out_valid, "write request produced a result")

  `STFS_ASSERT_NEXT(a_lookup_busy,
    in_valid && in_ready && (command == stfs_pkg::CMD_LOOKUP), !in_ready,
    "new request taken while a lookup is in progress")

endmodule

bind sorted_table_floor_search_unit stfs_checker u_stfs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .command       (command),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .found         (found),
  .record_offset (record_offset)
);
